### rtl/gsi_pkg.sv
// shared types, constants and the divider step for the gain schedule interpolator
package gsi_pkg;

   localparam int TIME_W      = 16;
   localparam int GAIN_W      = 24;
   localparam int DELTA_W     = GAIN_W + 1;
   localparam int FRAC_W      = 16;
   localparam int QUO_W       = FRAC_W + 1;
   localparam int MODE_W      = 2;
   localparam int COUNT_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int DIV_STAGES  = 4;
   localparam int DIV_STEPS   = FRAC_W / DIV_STAGES;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_COUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT0      = 3'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_INTERP = 2'd0,
      MODE_FIRST  = 2'd1,
      MODE_LAST   = 2'd2
   } gain_mode_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] kd;
      logic signed [GAIN_W-1:0] kp;
      logic [TIME_W-1:0]        bp_time;
   } point_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0]  base_p;
      logic signed [GAIN_W-1:0]  base_d;
      logic signed [DELTA_W-1:0] delta_p;
      logic signed [DELTA_W-1:0] delta_d;
   } item_type;

   typedef struct packed {
      logic [TIME_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
   } div_state_type;

   // one restoring division step, a zero bit shifted into the remainder
   function automatic div_state_type div_step(div_state_type st, logic [TIME_W-1:0] den);
      logic [TIME_W:0] trial;
      div_state_type   res;
      trial = {st.rem, 1'b0};
      if (trial >= {1'b0, den}) begin
         res.rem = TIME_W'(trial - {1'b0, den});
         res.quo = {st.quo[QUO_W-2:0], 1'b1};
      end else begin
         res.rem = trial[TIME_W-1:0];
         res.quo = {st.quo[QUO_W-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

### rtl/gsi_select.sv
// breakpoint search and segment fetch: two pipeline stages ahead of the divider
module gsi_select #(
   parameter int NPTS = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [gsi_pkg::MODE_W-1:0]            gain_mode,
   input  logic [gsi_pkg::COUNT_W-1:0]           point_count,
   input  gsi_pkg::point_type [NPTS-1:0]         points,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [gsi_pkg::TIME_W-1:0]            in_time,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [gsi_pkg::TIME_W-1:0]            out_num,
   output logic [gsi_pkg::TIME_W-1:0]            out_den,
   output gsi_pkg::item_type                     out_item
);
   import gsi_pkg::*;

   localparam int IDX_W = (NPTS > 1) ? $clog2(NPTS) : 1;

   typedef enum logic [1:0] {
      KIND_ZERO   = 2'd0,
      KIND_POINT  = 2'd1,
      KIND_INTERP = 2'd2
   } kind_type;

   // stage a: decide what the sample needs
   logic [COUNT_W-1:0] used_cnt;
   logic [COUNT_W-1:0] last_cnt;
   logic               past_last;
   logic [IDX_W-1:0]   last_idx;
   logic [IDX_W-1:0]   interp_idx;
   kind_type           kind_in;
   logic [IDX_W-1:0]   idx_in;

   logic               a_valid_ff;
   kind_type           a_kind_ff;
   logic [IDX_W-1:0]   a_idx_ff;
   logic [TIME_W-1:0]  a_time_ff;
   logic               a_adv;

   logic               b_valid_ff;
   logic [TIME_W-1:0]  b_num_ff;
   logic [TIME_W-1:0]  b_den_ff;
   item_type           b_item_ff;
   logic               b_adv;

   point_type          lo_pt;
   point_type          hi_pt;
   logic [TIME_W-1:0]  num_in;
   logic [TIME_W-1:0]  den_in;
   item_type           item_in;

   always_comb begin
      used_cnt   = (point_count > COUNT_W'(NPTS)) ? COUNT_W'(NPTS) : point_count;
      last_cnt   = used_cnt - COUNT_W'(1);
      past_last  = 1'b0;
      last_idx   = '0;
      interp_idx = '0;
      for (int k = 0; k < NPTS; k++) begin
         if (COUNT_W'(k) == last_cnt) begin
            last_idx  = IDX_W'(k);
            past_last = (in_time >= points[k].bp_time);
         end
      end
      // downward sweep leaves the lowest-indexed breakpoint (index 1 and up) at or above the sample
      for (int k = NPTS - 1; k >= 1; k--) begin
         if (COUNT_W'(k) < used_cnt && in_time <= points[k].bp_time) begin
            interp_idx = IDX_W'(k);
         end
      end
      priority if (used_cnt == '0) begin
         kind_in = KIND_ZERO;
         idx_in  = '0;
      end else if (gain_mode == MODE_FIRST) begin
         kind_in = KIND_POINT;
         idx_in  = '0;
      end else if (gain_mode == MODE_LAST) begin
         kind_in = KIND_POINT;
         idx_in  = last_idx;
      end else if (in_time <= points[0].bp_time) begin
         kind_in = KIND_POINT;
         idx_in  = '0;
      end else if (past_last) begin
         kind_in = KIND_POINT;
         idx_in  = last_idx;
      end else begin
         kind_in = KIND_INTERP;
         idx_in  = interp_idx;
      end
   end

   assign b_adv    = !b_valid_ff || out_ready;
   assign a_adv    = !a_valid_ff || b_adv;
   assign in_ready = a_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_adv) begin
         a_valid_ff <= in_valid;
      end
      if (a_adv && in_valid) begin
         a_kind_ff <= kind_in;
         a_idx_ff  <= idx_in;
         a_time_ff <= in_time;
      end
   end

   // stage b: fetch the segment ends and form dividend, divisor and deltas
   always_comb begin
      lo_pt = '0;
      hi_pt = '0;
      for (int k = 0; k < NPTS; k++) begin
         if (a_idx_ff == IDX_W'(k)) begin
            hi_pt = points[k];
         end
         if (k + 1 < NPTS && a_idx_ff == IDX_W'(k + 1)) begin
            lo_pt = points[k];
         end
      end
      unique case (a_kind_ff)
         KIND_INTERP: begin
            num_in          = a_time_ff - lo_pt.bp_time;
            den_in          = hi_pt.bp_time - lo_pt.bp_time;
            item_in.base_p  = lo_pt.kp;
            item_in.base_d  = lo_pt.kd;
            item_in.delta_p = DELTA_W'(hi_pt.kp) - DELTA_W'(lo_pt.kp);
            item_in.delta_d = DELTA_W'(hi_pt.kd) - DELTA_W'(lo_pt.kd);
         end
         KIND_POINT: begin
            num_in          = '0;
            den_in          = TIME_W'(1);
            item_in.base_p  = hi_pt.kp;
            item_in.base_d  = hi_pt.kd;
            item_in.delta_p = '0;
            item_in.delta_d = '0;
         end
         default: begin
            num_in  = '0;
            den_in  = TIME_W'(1);
            item_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_adv) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_adv && a_valid_ff) begin
         b_num_ff  <= num_in;
         b_den_ff  <= den_in;
         b_item_ff <= item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_num   = b_num_ff;
   assign out_den   = b_den_ff;
   assign out_item  = b_item_ff;

endmodule

### rtl/gsi_divider.sv
// pipelined restoring divider for the 16-bit interpolation fraction
module gsi_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [gsi_pkg::TIME_W-1:0]    in_num,
   input  logic [gsi_pkg::TIME_W-1:0]    in_den,
   input  gsi_pkg::item_type             in_item,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [gsi_pkg::QUO_W-1:0]     out_quo,
   output gsi_pkg::item_type             out_item
);
   import gsi_pkg::*;

   localparam int LAST = DIV_STAGES - 1;

   logic              valid_ff [DIV_STAGES];
   logic [TIME_W-1:0] rem_ff   [DIV_STAGES];
   logic [QUO_W-1:0]  quo_ff   [DIV_STAGES];
   logic [TIME_W-1:0] den_ff   [DIV_STAGES];
   item_type          item_ff  [DIV_STAGES];
   logic              adv      [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      div_state_type     st_in;
      div_state_type     st_out;
      logic [TIME_W-1:0] den_src;
      item_type          item_src;
      logic              valid_src;
      logic              down_ready;

      if (s == 0) begin : g_first
         // numerator never exceeds divisor, so the top quotient bit is a compare
         always_comb begin
            if (in_num >= in_den) begin
               st_in.rem = in_num - in_den;
               st_in.quo = QUO_W'(1);
            end else begin
               st_in.rem = in_num;
               st_in.quo = '0;
            end
         end
         assign den_src   = in_den;
         assign item_src  = in_item;
         assign valid_src = in_valid;
      end else begin : g_next
         assign st_in.rem = rem_ff[s-1];
         assign st_in.quo = quo_ff[s-1];
         assign den_src   = den_ff[s-1];
         assign item_src  = item_ff[s-1];
         assign valid_src = valid_ff[s-1];
      end

      if (s == LAST) begin : g_tail
         assign down_ready = out_ready;
      end else begin : g_body
         assign down_ready = adv[s+1];
      end

      always_comb begin
         st_out = st_in;
         for (int j = 0; j < DIV_STEPS; j++) begin
            st_out = div_step(st_out, den_src);
         end
      end

      assign adv[s] = !valid_ff[s] || down_ready;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            valid_ff[s] <= valid_src;
         end
         if (adv[s] && valid_src) begin
            rem_ff[s]  <= st_out.rem;
            quo_ff[s]  <= st_out.quo;
            den_ff[s]  <= den_src;
            item_ff[s] <= item_src;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[LAST];
   assign out_quo   = quo_ff[LAST];
   assign out_item  = item_ff[LAST];

endmodule

### rtl/gsi_blend.sv
// delta times ratio, floor to q12.12 and add the segment base; holds the result register
module gsi_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [gsi_pkg::QUO_W-1:0]         in_quo,
   input  gsi_pkg::item_type                 in_item,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [gsi_pkg::GAIN_W-1:0] out_gain_p,
   output logic signed [gsi_pkg::GAIN_W-1:0] out_gain_d
);
   import gsi_pkg::*;

   localparam int PROD_W = DELTA_W + QUO_W + 1;

   logic signed [PROD_W-1:0] prod_p_in;
   logic signed [PROD_W-1:0] prod_d_in;

   logic                     m_valid_ff;
   logic signed [GAIN_W-1:0] m_base_p_ff;
   logic signed [GAIN_W-1:0] m_base_d_ff;
   logic signed [GAIN_W-1:0] m_frac_p_ff;
   logic signed [GAIN_W-1:0] m_frac_d_ff;
   logic                     m_adv;

   logic                     o_valid_ff;
   logic signed [GAIN_W-1:0] o_gain_p_ff;
   logic signed [GAIN_W-1:0] o_gain_d_ff;
   logic                     o_adv;

   assign prod_p_in = PROD_W'(in_item.delta_p) * PROD_W'($signed({1'b0, in_quo}));
   assign prod_d_in = PROD_W'(in_item.delta_d) * PROD_W'($signed({1'b0, in_quo}));

   assign o_adv    = !o_valid_ff || out_ready;
   assign m_adv    = !m_valid_ff || o_adv;
   assign in_ready = m_adv;

   // arithmetic shift then keep 24 bits: floor of the product, modulo the gain width
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (m_adv) begin
         m_valid_ff <= in_valid;
      end
      if (m_adv && in_valid) begin
         m_base_p_ff <= in_item.base_p;
         m_base_d_ff <= in_item.base_d;
         m_frac_p_ff <= prod_p_in[FRAC_W +: GAIN_W];
         m_frac_d_ff <= prod_d_in[FRAC_W +: GAIN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_adv) begin
         o_valid_ff <= m_valid_ff;
      end
      if (o_adv && m_valid_ff) begin
         o_gain_p_ff <= m_base_p_ff + m_frac_p_ff;
         o_gain_d_ff <= m_base_d_ff + m_frac_d_ff;
      end
   end

   assign out_valid  = o_valid_ff;
   assign out_gain_p = o_gain_p_ff;
   assign out_gain_d = o_gain_d_ff;

endmodule

### rtl/gain_schedule_interpolator.sv
// top level of the piecewise-linear gain schedule interpolator
//
// req channel: one support-time beat per accept (req_valid and req_ready high).
// rsp channel: one beat of proportional and derivative gain per request, in order.
// csr port: a write at every clock with csr_we high; index 0 gain mode, 1 point
// count, 2 and up table points. The user writes only while no request is in
// flight; the block itself does not enforce it. Throughput: one beat per cycle,
// sustained with no bubbles while rsp_ready stays high. A result passes through two
// search/fetch stages, four divider stages (four quotient bits each, the first
// also taking the top bit), one multiply stage and the result register.
// Every stage holds a valid bit and advances when it is empty or the next one
// moves, so a stalled rsp side fills the pipe and only then drops req_ready;
// req_ready stays high whenever the result register is free or being taken.
// Reset empties the pipe and clears mode, count and all table points to zero;
// req_ready is high in the first cycle after reset.
module gain_schedule_interpolator #(
   parameter int MAX_POINTS = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [gsi_pkg::TIME_W-1:0]            req_support_time,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [gsi_pkg::GAIN_W-1:0]     rsp_gain_p,
   output logic signed [gsi_pkg::GAIN_W-1:0]     rsp_gain_d,
   input  logic                                  csr_we,
   input  logic [gsi_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [gsi_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import gsi_pkg::*;

   logic [MODE_W-1:0]             gain_mode_ff;
   logic [COUNT_W-1:0]            point_count_ff;
   point_type [MAX_POINTS-1:0]    point_ff;

   logic              sel_valid;
   logic              sel_ready;
   logic [TIME_W-1:0] sel_num;
   logic [TIME_W-1:0] sel_den;
   item_type          sel_item;

   logic              div_valid;
   logic              div_ready;
   logic [QUO_W-1:0]  div_quo;
   item_type          div_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_mode_ff   <= '0;
         point_count_ff <= '0;
         point_ff       <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_GAIN_MODE) begin
            gain_mode_ff <= csr_wdata[MODE_W-1:0];
         end
         if (csr_index == CSR_POINT_COUNT) begin
            point_count_ff <= csr_wdata[COUNT_W-1:0];
         end
         // points beyond the table size are never read, so their writes are dropped
         for (int k = 0; k < MAX_POINTS; k++) begin
            if (csr_index == CSR_INDEX_W'(int'(CSR_POINT0) + k)) begin
               point_ff[k] <= point_type'(csr_wdata);
            end
         end
      end
   end

   gsi_select #(
      .NPTS (MAX_POINTS)
   ) u_select (
      .clock       (clock),
      .reset       (reset),
      .gain_mode   (gain_mode_ff),
      .point_count (point_count_ff),
      .points      (point_ff),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_time     (req_support_time),
      .out_valid   (sel_valid),
      .out_ready   (sel_ready),
      .out_num     (sel_num),
      .out_den     (sel_den),
      .out_item    (sel_item)
   );

   gsi_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_ready  (sel_ready),
      .in_num    (sel_num),
      .in_den    (sel_den),
      .in_item   (sel_item),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_quo   (div_quo),
      .out_item  (div_item)
   );

   gsi_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_ready   (div_ready),
      .in_quo     (div_quo),
      .in_item    (div_item),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_gain_p (rsp_gain_p),
      .out_gain_d (rsp_gain_d)
   );

endmodule

### rtl/gsi_checker.sv
// port-level checks for the gain schedule interpolator, bound to the top level
module gsi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [gsi_pkg::GAIN_W-1:0] rsp_gain_p,
   input logic signed [gsi_pkg::GAIN_W-1:0] rsp_gain_d
);

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gain_p) && $stable(rsp_gain_d))
      else $error("rsp beat changed or dropped while stalled");

   // reset leaves an empty pipe that takes a request right away
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipe not empty after reset");

   // back pressure reaches the request side only through a stalled result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without a stalled rsp beat");

   // a freshly drained result register never blocks the request side
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("req_ready low while the result is taken");

endmodule

bind gain_schedule_interpolator gsi_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_gain_p (rsp_gain_p),
   .rsp_gain_d (rsp_gain_d)
);

### tb/sv/testbench.sv
// testbench for the gain schedule interpolator: scoreboard class, drivers and checks
module testbench;
   import gsi_pkg::*;

   localparam int TABLE_PTS = 6;
   localparam int BEATS_PER_SETTING = 56;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic signed [GAIN_W-1:0] GAIN_MIN = 24'sh800000;
   localparam logic signed [GAIN_W-1:0] GAIN_MAX = 24'sh7fffff;

   typedef struct {
      logic signed [GAIN_W-1:0] p;
      logic signed [GAIN_W-1:0] d;
   } gain_pair;

   class gain_checker;
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
      point_type          pts[TABLE_PTS];
      gain_pair           pending[$];
      int                 mismatches;
      int                 checked;

      function new();
         mode = MODE_INTERP;
         count = '0;
         foreach (pts[k]) pts[k] = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_GAIN_MODE)
            mode = data[MODE_W-1:0];
         else if (idx == CSR_POINT_COUNT)
            count = data[COUNT_W-1:0];
         else
            pts[int'(idx) - int'(CSR_POINT0)] = point_type'(data);
      endfunction

      function gain_pair point_gain(int k);
         gain_pair g;
         g.p = pts[k].kp;
         g.d = pts[k].kd;
         return g;
      endfunction

      // lo + floor((hi - lo) * ratio / 2^16)
      function logic signed [GAIN_W-1:0] blend(logic signed [GAIN_W-1:0] lo_g,
                                               logic signed [GAIN_W-1:0] hi_g,
                                               longint ratio);
         longint delta;
         delta = longint'(hi_g) - longint'(lo_g);
         return GAIN_W'(longint'(lo_g) + ((delta * ratio) >>> FRAC_W));
      endfunction

      function gain_pair scheduled_gain(logic [TIME_W-1:0] t);
         gain_pair g;
         int       n;
         int       last;
         longint   lo;
         longint   hi;
         longint   ratio;
         g.p = '0;
         g.d = '0;
         n = (count > TABLE_PTS) ? TABLE_PTS : int'(count);
         if (n == 0)
            return g;
         last = n - 1;
         if (mode == MODE_FIRST)
            return point_gain(0);
         if (mode == MODE_LAST)
            return point_gain(last);
         if (t <= pts[0].bp_time)
            return point_gain(0);
         if (t >= pts[last].bp_time)
            return point_gain(last);
         // first breakpoint at or above the sample, even in an unordered table
         for (int i = 1; i < n; i++) begin
            if (t <= pts[i].bp_time) begin
               lo = pts[i-1].bp_time;
               hi = pts[i].bp_time;
               ratio = ((longint'(t) - lo) << FRAC_W) / (hi - lo);
               g.p = blend(pts[i-1].kp, pts[i].kp, ratio);
               g.d = blend(pts[i-1].kd, pts[i].kd, ratio);
               return g;
            end
         end
         return point_gain(last);
      endfunction

      function void note_sample(logic [TIME_W-1:0] t);
         pending.push_back(scheduled_gain(t));
      endfunction

      function void check_beat(logic signed [GAIN_W-1:0] p, logic signed [GAIN_W-1:0] d);
         gain_pair want;
         if (pending.size() == 0) begin
            mismatches++;
            $display("%0t: gain beat p=%0d d=%0d with nothing expected", $time, p, d);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (p !== want.p) begin
            mismatches++;
            $display("%0t: gain_p expected %0d got %0d", $time, want.p, p);
         end
         if (d !== want.d) begin
            mismatches++;
            $display("%0t: gain_d expected %0d got %0d", $time, want.d, d);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [TIME_W-1:0]        req_support_time = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [GAIN_W-1:0] rsp_gain_p;
   logic signed [GAIN_W-1:0] rsp_gain_d;
   logic                     csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   gain_checker gains = new();
   point_type   plan[TABLE_PTS];
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          settings_loaded = 0;
   int          samples_sent = 0;

   gain_schedule_interpolator #(.MAX_POINTS(TABLE_PTS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_support_time (req_support_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_gain_p       (rsp_gain_p),
      .rsp_gain_d       (rsp_gain_d),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("testbench NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         gains.check_beat(rsp_gain_p, rsp_gain_d);
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      gains.write_reg(idx, data);
   endtask

   task automatic load_setting(logic [MODE_W-1:0] gmode, logic [COUNT_W-1:0] npts);
      csr_write(CSR_GAIN_MODE, CSR_DATA_W'(gmode));
      csr_write(CSR_POINT_COUNT, CSR_DATA_W'(npts));
      for (int k = 0; k < TABLE_PTS; k++)
         csr_write(CSR_POINT0 + CSR_INDEX_W'(k), CSR_DATA_W'(plan[k]));
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   task automatic set_point(int k, logic [TIME_W-1:0] bp, logic signed [GAIN_W-1:0] kp,
                            logic signed [GAIN_W-1:0] kd);
      plan[k].bp_time = bp;
      plan[k].kp = kp;
      plan[k].kd = kd;
   endtask

   task automatic send_sample(logic [TIME_W-1:0] t);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_support_time <= t;
      do @(posedge clock); while (!req_ready);
      gains.note_sample(t);
      samples_sent++;
   endtask

   // every request gives a result, so an empty queue plus the pipe depth means idle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (gains.pending.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                 tq[$];
      int                 eff;
      int                 last;
      int                 pick;
      int                 spread;
      int                 base;
      bit                 narrow;
      bit                 ordered;
      logic [MODE_W-1:0]  gm;
      logic [COUNT_W-1:0] gc;
      logic [TIME_W-1:0]  t;

      foreach (plan[k]) plan[k] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table straight out of reset, then in fixed mode
      send_sample(16'h0000);
      send_sample(16'hffff);
      wait_idle();
      load_setting(MODE_FIRST, 3'd0);
      send_sample(16'd1234);
      wait_idle();

      // full table with the breakpoint and gain extremes
      set_point(0, 16'd0, GAIN_MIN, GAIN_MAX);
      set_point(1, 16'd1, GAIN_MAX, GAIN_MIN);
      set_point(2, 16'd1000, 24'sd0, -24'sd1);
      set_point(3, 16'd30000, -24'sd1, 24'sd0);
      set_point(4, 16'd65534, GAIN_MAX, GAIN_MIN);
      set_point(5, 16'd65535, GAIN_MIN, GAIN_MAX);
      load_setting(MODE_INTERP, 3'd6);
      send_sample(16'd0);
      send_sample(16'd1);
      send_sample(16'd500);
      send_sample(16'd1000);
      send_sample(16'd29999);
      send_sample(16'd15000);
      send_sample(16'd65000);
      send_sample(16'd65534);
      send_sample(16'd65535);
      wait_idle();
      load_setting(MODE_LAST, 3'd6);
      send_sample(16'd100);
      wait_idle();
      load_setting(MODE_FIRST, 3'd6);
      send_sample(16'd100);
      wait_idle();
      load_setting(MODE_UNUSED, 3'd6);
      send_sample(16'd500);
      send_sample(16'd20000);
      wait_idle();
      // count above the table size acts as a full table
      load_setting(MODE_INTERP, 3'd7);
      send_sample(16'd65000);
      wait_idle();
      load_setting(MODE_INTERP, 3'd1);
      send_sample(16'd0);
      send_sample(16'd40000);
      wait_idle();

      // unordered breakpoints
      set_point(0, 16'd500, 24'sd4096, -24'sd4096);
      set_point(1, 16'd100, -24'sd8192, 24'sd100);
      set_point(2, 16'd800, 24'sd12345, -24'sd777);
      set_point(3, 16'd300, GAIN_MIN, GAIN_MAX);
      set_point(4, 16'd2000, GAIN_MAX, GAIN_MIN);
      set_point(5, 16'd50, 24'sd1, 24'sd2);
      load_setting(MODE_INTERP, 3'd5);
      send_sample(16'd600);
      send_sample(16'd900);
      send_sample(16'd300);

      for (int prof = 0; prof < 4; prof++) begin
         case (prof)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
            default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         endcase
         for (int s = 0; s < 6; s++) begin
            wait_idle();
            pick = $urandom_range(9);
            gm = (pick == 0) ? MODE_FIRST : (pick == 1) ? MODE_LAST :
                 (pick == 2) ? MODE_UNUSED : MODE_INTERP;
            pick = $urandom_range(19);
            gc = (pick == 0) ? 3'd0 : (pick == 1) ? 3'd1 : (pick == 2) ? 3'd7 :
                 COUNT_W'($urandom_range(2, 6));
            narrow = $urandom_range(1);
            ordered = ($urandom_range(9) != 0);
            spread = $urandom_range(1, 300);
            base = $urandom_range(65535 - spread);
            tq.delete();
            for (int k = 0; k < TABLE_PTS; k++)
               tq.push_back(narrow ? base + $urandom_range(spread) : $urandom_range(65535));
            if (ordered)
               tq.sort();
            for (int k = 0; k < TABLE_PTS; k++) begin
               plan[k].bp_time = TIME_W'(tq[k]);
               plan[k].kp = GAIN_W'($urandom());
               plan[k].kd = GAIN_W'($urandom());
               if ($urandom_range(7) == 0) begin
                  plan[k].kp = GAIN_W'(int'($urandom_range(2000)) - 1000);
                  plan[k].kd = GAIN_W'(int'($urandom_range(2000)) - 1000);
               end
            end
            load_setting(gm, gc);
            eff = (gc > TABLE_PTS) ? TABLE_PTS : int'(gc);
            last = (eff == 0) ? 0 : eff - 1;
            repeat (BEATS_PER_SETTING) begin
               pick = $urandom_range(9);
               if (pick < 2)
                  t = TIME_W'($urandom_range(65535));
               else if (pick < 4)
                  t = TIME_W'(plan[$urandom_range(last)].bp_time + $urandom_range(2) - 1);
               else
                  t = TIME_W'($urandom_range(plan[0].bp_time, plan[last].bp_time));
               send_sample(t);
            end
         end
      end
      wait_idle();

      $display("%0d gain beats checked for %0d samples over %0d table settings",
               gains.checked, samples_sent, settings_loaded);
      $display("all modes, counts 0 to 7, ordered and unordered tables, four handshake mixes");
      if (gains.mismatches == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

### files.f
rtl/gsi_pkg.sv
rtl/gsi_select.sv
rtl/gsi_divider.sv
rtl/gsi_blend.sv
rtl/gain_schedule_interpolator.sv
rtl/gsi_checker.sv
tb/sv/testbench.sv
